// ===== src/dtt_pkg.sv =====
`default_nettype none

package dtt_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int ADDR_SLOTS    = 16;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_DEL = 2'd1;
  localparam logic [1:0] KIND_EXP = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_ARMED = 2'd1;
  localparam logic [1:0] STAT_FREE  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEARCH,
    ST_RD,
    ST_WB
  } state_t;

endpackage

`default_nettype wire

// ===== src/deadline_timer_table_core.sv =====
// deadline timer table: SLOTS timer slots kept in one synchronous memory
// holding {one_shot, interval, deadline} per slot; valid bits sit in flops.
// input channel (in_*): one item per command: add, delete or tick.
// result channel (out_*): add and delete give one acknowledge item each,
// a tick gives one expiry item per due slot, oldest deadline first, ties to
// the lower slot; out_tlast marks the final item of a command.
// add and delete are done in the idle state; the acknowledge is registered and shows
// on the next cycle.
// a tick first reads every addressable slot from the memory (one read per
// cycle), then for each expiry makes a pass over the captured ages to pick
// the oldest, a memory read and a write-back of the re-armed deadline (a
// one-shot slot is freed instead). SCAN is the number of addressable slots, min(SLOTS, 16).
// a command 3 is accepted and dropped with no result.
// reset clears the tick counter, all valid bits and the output valid flag.
// when the receiver stalls, the result is held in the output register and
// the block waits; no new item is taken until the previous one is done.
`default_nettype none

module deadline_timer_table_core #(
  parameter int SLOTS     = dtt_pkg::SLOTS_DEF,
  parameter int TIME_BITS = dtt_pkg::TIME_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // command[1:0], slot_id[5:2], interval[21:6], one_shot[22], zero[23]
  input  wire logic [23:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[1:0], timer_slot[5:2], was_periodic[6], zero[7]
  output logic [7:0]       out_tdata,
  // kind[1:0]
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCAN = (SLOTS < dtt_pkg::ADDR_SLOTS) ? SLOTS : dtt_pkg::ADDR_SLOTS;
  localparam int TB   = TIME_BITS;
  localparam int EW   = 1 + 16 + TB;

  logic [1:0]  in_cmd;
  logic [3:0]  in_sid;
  logic [15:0] in_ivl;
  logic        in_once;
  assign in_cmd  = in_tdata[1:0];
  assign in_sid  = in_tdata[5:2];
  assign in_ivl  = in_tdata[21:6];
  assign in_once = in_tdata[22];

  dtt_pkg::state_t state_r, state_nxt;

  logic [TB-1:0]   now_r, now_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [IW:0]     cnt_r, cnt_nxt;
  logic [IW:0]     due_cnt_r, due_cnt_nxt;
  logic [SCAN-1:0] due_r, due_nxt;
  logic [TB-2:0]   age_r [SCAN];
  logic [TB-2:0]   age_nxt [SCAN];
  logic [TB-2:0]   best_age_r, best_age_nxt;
  logic [IW-1:0]   best_idx_r, best_idx_nxt;
  logic            found_r, found_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_kind_r, out_kind_nxt;
  logic [1:0]      out_stat_r, out_stat_nxt;
  logic [3:0]      out_slot_r, out_slot_nxt;
  logic            out_per_r, out_per_nxt;
  logic            out_last_r, out_last_nxt;

  logic [EW-1:0]   slot_mem_r [SLOTS];
  logic [EW-1:0]   rdata_r;
  logic [IW-1:0]   rd_addr;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  logic [EW-1:0]   mem_wdata;

  logic            out_free;
  logic            in_acc;
  logic [IW+3:0]   sid_w;
  logic            sid_ok;
  logic [IW-1:0]   sid_idx;
  logic [IW:0]     cm1;
  logic [IW-1:0]   pidx;
  logic [IW-1:0]   sidx;
  logic [TB-1:0]   diff;
  logic            rd_once;
  logic [15:0]     rd_ivl;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == dtt_pkg::ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign sid_w     = (IW + 4)'(in_sid);
  assign sid_ok    = sid_w < (IW + 4)'(SLOTS);
  assign sid_idx   = sid_w[IW-1:0];
  assign cm1       = cnt_r - 1'b1;
  assign pidx      = cm1[IW-1:0];
  assign sidx      = cnt_r[IW-1:0];
  assign diff      = now_r - rdata_r[TB-1:0];
  assign rd_once   = rdata_r[EW-1];
  assign rd_ivl    = rdata_r[TB+15:TB];
  assign rd_addr   = (state_r == dtt_pkg::ST_SCAN) ? sidx : best_idx_r;

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem_r[mem_waddr] <= mem_wdata;
    end
    rdata_r <= slot_mem_r[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dtt_pkg::ST_IDLE: begin
        if (in_acc && in_cmd == dtt_pkg::CMD_TICK) state_nxt = dtt_pkg::ST_SCAN;
      end
      dtt_pkg::ST_SCAN: begin
        if (cnt_r == (IW + 1)'(SCAN)) begin
          state_nxt = (due_cnt_nxt == '0) ? dtt_pkg::ST_IDLE : dtt_pkg::ST_SEARCH;
        end
      end
      dtt_pkg::ST_SEARCH: begin
        if (cnt_r == (IW + 1)'(SCAN - 1)) state_nxt = dtt_pkg::ST_RD;
      end
      dtt_pkg::ST_RD: state_nxt = dtt_pkg::ST_WB;
      dtt_pkg::ST_WB: begin
        if (out_free) begin
          state_nxt = (due_cnt_r == (IW + 1)'(1)) ? dtt_pkg::ST_IDLE : dtt_pkg::ST_SEARCH;
        end
      end
      default: state_nxt = dtt_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    now_nxt       = now_r;
    valid_nxt     = valid_r;
    cnt_nxt       = cnt_r;
    due_cnt_nxt   = due_cnt_r;
    due_nxt       = due_r;
    age_nxt       = age_r;
    best_age_nxt  = best_age_r;
    best_idx_nxt  = best_idx_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_stat_nxt  = out_stat_r;
    out_slot_nxt  = out_slot_r;
    out_per_nxt   = out_per_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = sid_idx;
    mem_wdata     = {in_once, in_ivl, now_r + TB'(in_ivl)};
    case (state_r)
      dtt_pkg::ST_IDLE: begin
        if (in_acc) begin
          out_slot_nxt = in_sid;
          out_per_nxt  = 1'b0;
          out_last_nxt = 1'b1;
          case (in_cmd)
            dtt_pkg::CMD_ADD: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = dtt_pkg::KIND_ADD;
              if (!sid_ok) begin
                out_stat_nxt = dtt_pkg::STAT_FREE;
              end else if (valid_r[sid_idx]) begin
                out_stat_nxt = dtt_pkg::STAT_ARMED;
              end else begin
                out_stat_nxt       = dtt_pkg::STAT_OK;
                valid_nxt[sid_idx] = 1'b1;
                mem_we             = 1'b1;
              end
            end
            dtt_pkg::CMD_DEL: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = dtt_pkg::KIND_DEL;
              if (sid_ok && valid_r[sid_idx]) begin
                out_stat_nxt       = dtt_pkg::STAT_OK;
                valid_nxt[sid_idx] = 1'b0;
              end else begin
                out_stat_nxt = dtt_pkg::STAT_FREE;
              end
            end
            dtt_pkg::CMD_TICK: begin
              now_nxt     = now_r + 1'b1;
              cnt_nxt     = '0;
              due_cnt_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      dtt_pkg::ST_SCAN: begin
        // data of the slot read in the previous cycle
        if (cnt_r != '0) begin
          if (valid_r[pidx] && !diff[TB-1]) begin
            due_nxt[pidx] = 1'b1;
            age_nxt[pidx] = diff[TB-2:0];
            due_cnt_nxt   = due_cnt_r + 1'b1;
          end else begin
            due_nxt[pidx] = 1'b0;
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (IW + 1)'(SCAN)) begin
          cnt_nxt   = '0;
          found_nxt = 1'b0;
        end
      end
      dtt_pkg::ST_SEARCH: begin
        // strict compare keeps the lower slot on equal age
        if (due_r[sidx] && (!found_r || age_r[sidx] > best_age_r)) begin
          found_nxt    = 1'b1;
          best_age_nxt = age_r[sidx];
          best_idx_nxt = sidx;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      dtt_pkg::ST_RD: ;
      dtt_pkg::ST_WB: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = dtt_pkg::KIND_EXP;
          out_stat_nxt  = dtt_pkg::STAT_OK;
          out_slot_nxt  = 4'(best_idx_r);
          out_per_nxt   = !rd_once;
          out_last_nxt  = (due_cnt_r == (IW + 1)'(1));
          due_cnt_nxt   = due_cnt_r - 1'b1;
          due_nxt[best_idx_r] = 1'b0;
          cnt_nxt       = '0;
          found_nxt     = 1'b0;
          if (rd_once) begin
            valid_nxt[best_idx_r] = 1'b0;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = best_idx_r;
            mem_wdata = {rd_once, rd_ivl, now_r + TB'(rd_ivl)};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dtt_pkg::ST_IDLE;
      now_r       <= '0;
      valid_r     <= '0;
      cnt_r       <= '0;
      due_cnt_r   <= '0;
      due_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      due_cnt_r   <= due_cnt_nxt;
      due_r       <= due_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    age_r      <= age_nxt;
    best_age_r <= best_age_nxt;
    best_idx_r <= best_idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_stat_r <= out_stat_nxt;
    out_slot_r <= out_slot_nxt;
    out_per_r  <= out_per_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_per_r, out_slot_r, out_stat_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_search_has_due: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dtt_pkg::ST_SEARCH |-> due_cnt_r != '0)
    else $error("search pass with no due slot");

  a_wb_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dtt_pkg::ST_WB && !out_valid_r) |=> out_valid_r)
    else $error("expiry not emitted");

  a_exp_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == dtt_pkg::KIND_EXP) |-> out_stat_r == dtt_pkg::STAT_OK)
    else $error("expiry with bad status");
`endif

endmodule

`default_nettype wire
